### rtl/binary_extended_gcd_unit_defines.svh
// assertion macros shared by the gcd unit
`ifndef BINARY_EXTENDED_GCD_UNIT_DEFINES_SVH
`define BINARY_EXTENDED_GCD_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define XGCD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define XGCD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/xgcd_pkg.sv
package xgcd_pkg;

    // default operand width and fixed result widths
    localparam int OPERAND_BITS_DEF = 32;
    localparam int GCD_BITS         = 32;
    localparam int COEF_BITS        = 33;
    localparam int COEF_MAX_BITS    = 64;

    // datapath operations issued by the sequencer
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_STRIP,
        OP_INIT,
        OP_HALVE_U,
        OP_HALVE_V,
        OP_SUB,
        OP_FINISH,
        OP_ERROR
    } t_op;

    // branch conditions
    typedef enum logic [2:0] {
        CND_NEVER,
        CND_NO_FIRE,
        CND_ZERO,
        CND_BOTH_EVEN,
        CND_U_EVEN,
        CND_V_EVEN,
        CND_NOT_EQ,
        CND_OUT_BUSY
    } t_cond;

    // when the step's operation fires
    typedef enum logic [1:0] {
        EX_ALWAYS,
        EX_COND,
        EX_NCOND
    } t_exec;

    // microprogram steps
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_STRIP,
        ST_INIT,
        ST_HALVE_U,
        ST_HALVE_V,
        ST_SUB,
        ST_SCALE,
        ST_ERROR
    } t_step;

    // one control word
    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_exec exec;
        t_step jmp_t;
        t_step jmp_f;
    } t_uword;

    // datapath status seen by the sequencer
    typedef struct packed {
        logic zero;
        logic both_even;
        logic u_even;
        logic v_even;
        logic u_eq_v;
    } t_flags;

    // coefficient width: room for the intermediate sums, capped at 64 bits
    function automatic int coef_width(int ob);
        int t;
        t = ob + 3;
        if (t < COEF_BITS) begin
            t = COEF_BITS;
        end
        if (t > COEF_MAX_BITS) begin
            t = COEF_MAX_BITS;
        end
        return t;
    endfunction

    // microprogram rom
    function automatic t_uword xgcd_rom(t_step step);
        t_uword w;
        case (step)
            ST_IDLE:    w = '{OP_LOAD,    CND_NO_FIRE,   EX_NCOND,  ST_IDLE,    ST_CHECK};
            ST_CHECK:   w = '{OP_NOP,     CND_ZERO,      EX_ALWAYS, ST_ERROR,   ST_STRIP};
            ST_STRIP:   w = '{OP_STRIP,   CND_BOTH_EVEN, EX_COND,   ST_STRIP,   ST_INIT};
            ST_INIT:    w = '{OP_INIT,    CND_NEVER,     EX_ALWAYS, ST_INIT,    ST_HALVE_U};
            ST_HALVE_U: w = '{OP_HALVE_U, CND_U_EVEN,    EX_COND,   ST_HALVE_U, ST_HALVE_V};
            ST_HALVE_V: w = '{OP_HALVE_V, CND_V_EVEN,    EX_COND,   ST_HALVE_V, ST_SUB};
            ST_SUB:     w = '{OP_SUB,     CND_NOT_EQ,    EX_ALWAYS, ST_HALVE_U, ST_SCALE};
            ST_SCALE:   w = '{OP_FINISH,  CND_OUT_BUSY,  EX_NCOND,  ST_SCALE,   ST_IDLE};
            ST_ERROR:   w = '{OP_ERROR,   CND_OUT_BUSY,  EX_NCOND,  ST_ERROR,   ST_IDLE};
            default:    w = '{OP_NOP,     CND_NEVER,     EX_ALWAYS, ST_IDLE,    ST_IDLE};
        endcase
        return w;
    endfunction

endpackage

### rtl/xgcd_seq.sv
`include "binary_extended_gcd_unit_defines.svh"

module xgcd_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_out_busy,
    input  xgcd_pkg::t_flags i_flags,
    output logic            o_in_stall,
    output xgcd_pkg::t_op   o_op
);
    import xgcd_pkg::*;

    t_step  r_step;
    t_step  n_step;
    t_uword w_word;
    logic   w_cond;
    logic   w_exec;

    // fetch the control word of the current step
    assign w_word = xgcd_rom(r_step);

    // branch condition select
    always_comb begin
        case (w_word.cond)
            CND_NEVER:     w_cond = 1'b0;
            CND_NO_FIRE:   w_cond = !i_in_valid;
            CND_ZERO:      w_cond = i_flags.zero;
            CND_BOTH_EVEN: w_cond = i_flags.both_even;
            CND_U_EVEN:    w_cond = i_flags.u_even;
            CND_V_EVEN:    w_cond = i_flags.v_even;
            CND_NOT_EQ:    w_cond = !i_flags.u_eq_v;
            CND_OUT_BUSY:  w_cond = i_out_busy;
            default:       w_cond = 1'b0;
        endcase
    end

    // operation qualifier
    always_comb begin
        case (w_word.exec)
            EX_ALWAYS: w_exec = 1'b1;
            EX_COND:   w_exec = w_cond;
            EX_NCOND:  w_exec = !w_cond;
            default:   w_exec = 1'b0;
        endcase
    end

    assign o_op       = w_exec ? w_word.op : OP_NOP;
    assign o_in_stall = (r_step != ST_IDLE);
    assign n_step     = w_cond ? w_word.jmp_t : w_word.jmp_f;

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    `XGCD_ASSERT_NXT(a_load_then_check, o_op == OP_LOAD, r_step == ST_CHECK, "load not followed by check")
    `XGCD_ASSERT_IMP(a_no_write_busy, i_out_busy, (o_op != OP_FINISH) && (o_op != OP_ERROR), "result written while busy")

endmodule

### rtl/xgcd_dp.sv
`include "binary_extended_gcd_unit_defines.svh"

module xgcd_dp #(
    parameter  int OPERAND_BITS = xgcd_pkg::OPERAND_BITS_DEF,
    localparam int CW           = xgcd_pkg::coef_width(OPERAND_BITS),
    localparam int SHW          = $clog2(OPERAND_BITS)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  xgcd_pkg::t_op           i_op,
    input  logic [OPERAND_BITS-1:0] i_operand_x,
    input  logic [OPERAND_BITS-1:0] i_operand_y,
    output xgcd_pkg::t_flags        o_flags,
    output logic [OPERAND_BITS-1:0] o_v,
    output logic [CW-1:0]           o_va,
    output logic [CW-1:0]           o_vb,
    output logic [SHW-1:0]          o_shift
);
    import xgcd_pkg::*;

    logic [OPERAND_BITS-1:0] r_x, r_y, r_u, r_v;
    logic [CW-1:0]           r_ua, r_ub, r_va, r_vb;
    logic [SHW-1:0]          r_shift;

    logic                    w_sel_v;
    logic [OPERAND_BITS-1:0] w_row;
    logic [CW-1:0]           w_ca, w_cb, w_sa, w_sb, w_ha, w_hb;
    logic                    w_odd;
    logic                    w_ge;

    // shared halving unit, row chosen by the operation
    assign w_sel_v = (i_op == OP_HALVE_V);
    assign w_row   = w_sel_v ? r_v  : r_u;
    assign w_ca    = w_sel_v ? r_va : r_ua;
    assign w_cb    = w_sel_v ? r_vb : r_ub;
    assign w_odd   = w_ca[0] | w_cb[0];
    assign w_sa    = w_odd ? (w_ca + CW'(r_y)) : w_ca;
    assign w_sb    = w_odd ? (w_cb - CW'(r_x)) : w_cb;
    assign w_ha    = {w_sa[CW-1], w_sa[CW-1:1]};
    assign w_hb    = {w_sb[CW-1], w_sb[CW-1:1]};

    // subtraction direction
    assign w_ge = (r_u >= r_v);

    // status to the sequencer
    assign o_flags.zero      = (r_x == '0) || (r_y == '0);
    assign o_flags.both_even = !(r_x[0] | r_y[0]);
    assign o_flags.u_even    = !r_u[0];
    assign o_flags.v_even    = !r_v[0];
    assign o_flags.u_eq_v    = (r_u == r_v);

    assign o_v     = r_v;
    assign o_va    = r_va;
    assign o_vb    = r_vb;
    assign o_shift = r_shift;

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_LOAD: begin
                r_x     <= i_operand_x;
                r_y     <= i_operand_y;
                r_shift <= '0;
            end
            OP_STRIP: begin
                r_x     <= r_x >> 1;
                r_y     <= r_y >> 1;
                r_shift <= r_shift + SHW'(1);
            end
            OP_INIT: begin
                r_u  <= r_x;
                r_v  <= r_y;
                r_ua <= CW'(1);
                r_ub <= '0;
                r_va <= '0;
                r_vb <= CW'(1);
            end
            OP_HALVE_U: begin
                r_u  <= w_row >> 1;
                r_ua <= w_ha;
                r_ub <= w_hb;
            end
            OP_HALVE_V: begin
                r_v  <= w_row >> 1;
                r_va <= w_ha;
                r_vb <= w_hb;
            end
            OP_SUB: begin
                if (w_ge) begin
                    r_u  <= r_u - r_v;
                    r_ua <= r_ua - r_va;
                    r_ub <= r_ub - r_vb;
                end else begin
                    r_v  <= r_v - r_u;
                    r_va <= r_va - r_ua;
                    r_vb <= r_vb - r_ub;
                end
            end
            default: begin
            end
        endcase
    end

    `XGCD_ASSERT_IMP(a_halve_u_even, i_op == OP_HALVE_U, !r_u[0], "halving an odd u residue")
    `XGCD_ASSERT_IMP(a_sub_both_odd, i_op == OP_SUB, r_u[0] && r_v[0], "subtract on an even residue")

endmodule

### rtl/binary_extended_gcd_unit.sv
// sequencing: data dependent, one microstep per cycle, the result write waiting while the
// output slot is held; a zero operand goes from the check step straight to the error step
// throughput: one transaction at a time, the next is taken once the sequencer is idle,
// while the finished result may still wait in the output register
// reset: synchronous active low, clears the step counter and the output valid;
// no clearing pass
`include "binary_extended_gcd_unit_defines.svh"

module binary_extended_gcd_unit #(
    parameter  int OPERAND_BITS = xgcd_pkg::OPERAND_BITS_DEF,
    localparam int CW           = xgcd_pkg::coef_width(OPERAND_BITS),
    localparam int SHW          = $clog2(OPERAND_BITS)
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [OPERAND_BITS-1:0]          i_operand_x,
    input  logic [OPERAND_BITS-1:0]          i_operand_y,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [xgcd_pkg::GCD_BITS-1:0]    o_gcd_value,
    output logic signed [xgcd_pkg::COEF_BITS-1:0] o_coef_for_x,
    output logic signed [xgcd_pkg::COEF_BITS-1:0] o_coef_for_y,
    output logic                             o_zero_operand_error
);
    import xgcd_pkg::*;

    t_op                     w_op;
    t_flags                  w_flags;
    logic                    w_out_busy;
    logic [OPERAND_BITS-1:0] w_v;
    logic [CW-1:0]           w_va, w_vb;
    logic [SHW-1:0]          w_shift;
    logic [OPERAND_BITS-1:0] w_scaled;

    logic                    r_out_valid;
    logic [GCD_BITS-1:0]     r_gcd;
    logic [COEF_BITS-1:0]    r_ca, r_cb;
    logic                    r_err;

    // output slot is held when a result waits and the sink stalls
    assign w_out_busy = r_out_valid && i_out_stall;

    xgcd_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_out_busy (w_out_busy),
        .i_flags    (w_flags),
        .o_in_stall (o_in_stall),
        .o_op       (w_op)
    );

    xgcd_dp #(
        .OPERAND_BITS (OPERAND_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (w_op),
        .i_operand_x (i_operand_x),
        .i_operand_y (i_operand_y),
        .o_flags     (w_flags),
        .o_v         (w_v),
        .o_va        (w_va),
        .o_vb        (w_vb),
        .o_shift     (w_shift)
    );

    // restore the common power of two
    assign w_scaled = w_v << w_shift;

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((w_op == OP_FINISH) || (w_op == OP_ERROR)) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        case (w_op)
            OP_FINISH: begin
                r_gcd <= GCD_BITS'(w_scaled);
                r_ca  <= w_va[COEF_BITS-1:0];
                r_cb  <= w_vb[COEF_BITS-1:0];
                r_err <= 1'b0;
            end
            OP_ERROR: begin
                r_gcd <= '0;
                r_ca  <= '0;
                r_cb  <= '0;
                r_err <= 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid          = r_out_valid;
    assign o_gcd_value          = r_gcd;
    assign o_coef_for_x         = r_ca;
    assign o_coef_for_y         = r_cb;
    assign o_zero_operand_error = r_err;

    `XGCD_ASSERT_NXT(a_err_result, w_op == OP_ERROR, r_err && (r_gcd == '0), "bad error result")
    `XGCD_ASSERT_NXT(a_ok_result, w_op == OP_FINISH, !r_err && r_out_valid, "bad gcd result")

endmodule

### dv/binary_extended_gcd_unit_test.sv
`timescale 1ns / 100ps

module binary_extended_gcd_unit_test;

    import xgcd_pkg::*;

    localparam int OP_BITS        = OPERAND_BITS_DEF;
    localparam int DIRECTED_COUNT = 22;
    localparam int RANDOM_COUNT   = 550;
    localparam int TOTAL_COUNT    = DIRECTED_COUNT + RANDOM_COUNT;
    // worst case latency of one transaction plus some margin
    localparam int DRAIN_CYCLES   = 8 * OP_BITS + 24;
    localparam int MAX_SEND_GAP   = 8;

    // one expected result transaction
    typedef struct packed {
        logic [GCD_BITS-1:0]  gcd_value;
        logic [COEF_BITS-1:0] coef_for_x;
        logic [COEF_BITS-1:0] coef_for_y;
        logic                 zero_operand_error;
    } t_bezout_result;

    // one row of the directed table
    typedef struct packed {
        logic [OP_BITS-1:0] operand_x;
        logic [OP_BITS-1:0] operand_y;
        logic               typed;
        t_bezout_result     result;
    } t_gcd_vector;

    localparam t_bezout_result ZERO_OPERAND_RESULT = '{
        gcd_value: '0, coef_for_x: '0, coef_for_y: '0, zero_operand_error: 1'b1
    };
    localparam t_bezout_result FROM_PREDICTOR = '0;

    // directed table: zero operands typed in, the rest predicted
    t_gcd_vector directed_vectors [0:DIRECTED_COUNT-1] = '{
        '{32'h0000_0000, 32'h0000_0000, 1'b1, ZERO_OPERAND_RESULT},
        '{32'h0000_0000, 32'h0000_0001, 1'b1, ZERO_OPERAND_RESULT},
        '{32'hFFFF_FFFF, 32'h0000_0000, 1'b1, ZERO_OPERAND_RESULT},
        '{32'h0000_0000, 32'h8000_0000, 1'b1, ZERO_OPERAND_RESULT},
        '{32'h0000_0001, 32'h0000_0001, 1'b0, FROM_PREDICTOR},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, FROM_PREDICTOR},
        '{32'h0000_0001, 32'hFFFF_FFFF, 1'b0, FROM_PREDICTOR},
        '{32'hFFFF_FFFF, 32'h0000_0001, 1'b0, FROM_PREDICTOR},
        '{32'h8000_0000, 32'h8000_0000, 1'b0, FROM_PREDICTOR},
        '{32'h8000_0000, 32'h0000_0001, 1'b0, FROM_PREDICTOR},
        '{32'h0000_0001, 32'h8000_0000, 1'b0, FROM_PREDICTOR},
        '{32'h0000_0002, 32'h8000_0000, 1'b0, FROM_PREDICTOR},
        '{32'h0000_000C, 32'h0000_0012, 1'b0, FROM_PREDICTOR},
        '{32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b0, FROM_PREDICTOR},
        '{32'h7FFF_FFFF, 32'h8000_0000, 1'b0, FROM_PREDICTOR},
        '{32'hAAAA_AAAA, 32'h5555_5555, 1'b0, FROM_PREDICTOR},
        '{32'hB119_24E1, 32'h6D73_E55F, 1'b0, FROM_PREDICTOR},
        '{32'h0000_0030, 32'h0000_00B4, 1'b0, FROM_PREDICTOR},
        '{32'h0000_0002, 32'h0000_0003, 1'b0, FROM_PREDICTOR},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b0, FROM_PREDICTOR},
        '{32'hC000_0000, 32'h4000_0000, 1'b0, FROM_PREDICTOR},
        '{32'h0000_0007, 32'h0000_0007, 1'b0, FROM_PREDICTOR}
    };

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_in_valid = 1'b0;
    logic                        o_in_stall;
    logic [OP_BITS-1:0]          i_operand_x = '0;
    logic [OP_BITS-1:0]          i_operand_y = '0;
    logic                        o_out_valid;
    logic                        i_out_stall = 1'b0;
    logic [GCD_BITS-1:0]         o_gcd_value;
    logic signed [COEF_BITS-1:0] o_coef_for_x;
    logic signed [COEF_BITS-1:0] o_coef_for_y;
    logic                        o_zero_operand_error;

    t_bezout_result pending_bezout_q [$];
    int             mismatch_count = 0;
    int             send_idle_pct  = 33;
    int             recv_stall_pct = 66;

    binary_extended_gcd_unit u_dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .o_in_stall           (o_in_stall),
        .i_operand_x          (i_operand_x),
        .i_operand_y          (i_operand_y),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .o_gcd_value          (o_gcd_value),
        .o_coef_for_x         (o_coef_for_x),
        .o_coef_for_y         (o_coef_for_y),
        .o_zero_operand_error (o_zero_operand_error)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // halve a residue, fixing its coefficient pair so the identity still holds
    function automatic logic [191:0] halve_row(input logic [63:0] res, input logic [63:0] ca,
                                               input logic [63:0] cb, input logic [63:0] xs,
                                               input logic [63:0] ys);
        logic [63:0] na;
        logic [63:0] nb;
        if (ca[0] | cb[0]) begin
            na = ca + ys;
            nb = cb - xs;
        end else begin
            na = ca;
            nb = cb;
        end
        return {res >> 1, na[63], na[63:1], nb[63], nb[63:1]};
    endfunction

    // binary extended gcd, coefficients kept modulo 2^64
    function automatic t_bezout_result predict_bezout(input logic [OP_BITS-1:0] opx,
                                                      input logic [OP_BITS-1:0] opy);
        logic [63:0]    xs;
        logic [63:0]    ys;
        logic [63:0]    u;
        logic [63:0]    v;
        logic [63:0]    ua;
        logic [63:0]    ub;
        logic [63:0]    va;
        logic [63:0]    vb;
        logic [63:0]    scaled;
        int             shift;
        t_bezout_result res;
        res = '0;
        if (opx == '0 || opy == '0) begin
            res.zero_operand_error = 1'b1;
            return res;
        end
        xs = 64'(opx);
        ys = 64'(opy);
        shift = 0;
        // strip common powers of two
        while (!xs[0] && !ys[0]) begin
            xs = xs >> 1;
            ys = ys >> 1;
            shift++;
        end
        u  = xs;
        v  = ys;
        ua = 64'd1;
        ub = 64'd0;
        va = 64'd0;
        vb = 64'd1;
        do begin
            while (!u[0]) begin
                {u, ua, ub} = halve_row(u, ua, ub, xs, ys);
            end
            while (!v[0]) begin
                {v, va, vb} = halve_row(v, va, vb, xs, ys);
            end
            if (u >= v) begin
                u  = u - v;
                ua = ua - va;
                ub = ub - vb;
            end else begin
                v  = v - u;
                va = va - ua;
                vb = vb - ub;
            end
        end while (u != 64'd0);
        scaled = v << shift;
        res.gcd_value  = scaled[GCD_BITS-1:0];
        res.coef_for_x = va[COEF_BITS-1:0];
        res.coef_for_y = vb[COEF_BITS-1:0];
        return res;
    endfunction

    // idle mix by position in the run: sender light, then receiver light, then none
    task automatic pick_idle_phase(input int idx);
        if (idx < TOTAL_COUNT / 3) begin
            send_idle_pct  = 33;
            recv_stall_pct = 66;
        end else if (idx < 2 * TOTAL_COUNT / 3) begin
            send_idle_pct  = 66;
            recv_stall_pct = 33;
        end else begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
        end
    endtask

    // send one operand transaction, record its result once accepted
    task automatic drive_operands(input logic [OP_BITS-1:0] opx, input logic [OP_BITS-1:0] opy,
                                  input t_bezout_result expected);
        int gap;
        gap = 0;
        while (gap < MAX_SEND_GAP && $urandom_range(99) < send_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_operand_x <= opx;
        i_operand_y <= opy;
        do @(posedge i_clk); while (o_in_stall);
        pending_bezout_q.push_back(expected);
    endtask

    // result side back pressure
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // compare each result transaction with the oldest pending one
    always @(posedge i_clk) begin
        t_bezout_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_bezout_q.size() == 0) begin
                $error("result with no pending transaction: gcd_value %h", o_gcd_value);
                mismatch_count++;
            end else begin
                want = pending_bezout_q.pop_front();
                if (o_gcd_value !== want.gcd_value) begin
                    $error("gcd_value: expected %h, actual %h", want.gcd_value, o_gcd_value);
                    mismatch_count++;
                end
                if (o_coef_for_x !== want.coef_for_x) begin
                    $error("coef_for_x: expected %0d, actual %0d",
                           $signed(want.coef_for_x), o_coef_for_x);
                    mismatch_count++;
                end
                if (o_coef_for_y !== want.coef_for_y) begin
                    $error("coef_for_y: expected %0d, actual %0d",
                           $signed(want.coef_for_y), o_coef_for_y);
                    mismatch_count++;
                end
                if (o_zero_operand_error !== want.zero_operand_error) begin
                    $error("zero_operand_error: expected %b, actual %b",
                           want.zero_operand_error, o_zero_operand_error);
                    mismatch_count++;
                end
            end
        end
    end

    // main stimulus
    initial begin
        int unsigned        pick;
        int unsigned        shift_k;
        logic [OP_BITS-1:0] rx;
        logic [OP_BITS-1:0] ry;
        logic [OP_BITS-1:0] factor;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        for (int idx = 0; idx < DIRECTED_COUNT; idx++) begin
            pick_idle_phase(idx);
            drive_operands(directed_vectors[idx].operand_x, directed_vectors[idx].operand_y,
                           directed_vectors[idx].typed ? directed_vectors[idx].result :
                           predict_bezout(directed_vectors[idx].operand_x,
                                          directed_vectors[idx].operand_y));
        end

        // random operand pairs, weighted toward shared factors
        for (int idx = 0; idx < RANDOM_COUNT; idx++) begin
            pick_idle_phase(DIRECTED_COUNT + idx);
            pick = $urandom_range(99);
            if (pick < 3) begin
                // zero operand on one side or both
                rx = (pick == 0 || pick == 2) ? '0 : $urandom;
                ry = (pick == 1 || pick == 2) ? '0 : $urandom;
            end else if (pick < 35) begin
                rx = $urandom;
                ry = $urandom;
            end else if (pick < 55) begin
                // common power of two
                shift_k = $urandom_range(OP_BITS - 1);
                rx = $urandom << shift_k;
                ry = $urandom << shift_k;
            end else if (pick < 75) begin
                // common odd factor
                factor = $urandom_range(65535) | 1;
                rx = factor * $urandom_range(65535, 1);
                ry = factor * $urandom_range(65535, 1);
            end else if (pick < 85) begin
                rx = $urandom_range(255, 1);
                ry = $urandom_range(255, 1);
            end else if (pick < 90) begin
                rx = $urandom;
                ry = rx;
            end else begin
                // runs of ones against random values
                rx = {OP_BITS{1'b1}} >> $urandom_range(OP_BITS - 1);
                ry = $urandom;
                if (pick[0]) begin
                    {rx, ry} = {ry, rx};
                end
            end
            drive_operands(rx, ry, predict_bezout(rx, ry));
        end
        i_in_valid <= 1'b0;

        // drain
        while (pending_bezout_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_bezout_q.size() == 0) begin
            $display("binary_extended_gcd_unit_test: clean");
        end else begin
            $display("binary_extended_gcd_unit_test: errors");
        end
        $finish;
    end

    // watchdog
    initial begin
        #10_000_000;
        $display("binary_extended_gcd_unit_test: errors");
        $finish;
    end

endmodule
